// File: rtl/sgc_pkg.sv
`timescale 1ns / 1ps

package sgc_pkg;

    // default build sizes
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 4096;

    // fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int GRAD_BITS   = 20;
    localparam int SCALE_SHIFT = 12;
    localparam int COL_CNT_W   = 11;
    localparam int ROW_CNT_W   = 13;
    localparam int SCALE_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_SCALE = 2'd2;

    // configuration reset values
    localparam logic [COL_CNT_W-1:0] COL_COUNT_RST  = 11'd256;
    localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST  = 13'd256;
    localparam logic [SCALE_W-1:0]   GRAD_SCALE_RST = 16'd512;

    // input action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // input word
    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_in_word;

    // output word
    typedef struct packed {
        logic signed [GRAD_BITS-1:0] grad_x;
        logic signed [GRAD_BITS-1:0] grad_y;
        logic                        last_of_frame;
    } t_out_word;

    // one column of the 3x3 window
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] top;
        logic signed [SAMPLE_BITS-1:0] mid;
        logic signed [SAMPLE_BITS-1:0] bot;
    } t_win_col;

    // per-visit control handed from front to back
    typedef struct packed {
        logic upd;        // shift a new column into the window
        logic wr;         // write the line stores
        logic virt;       // row below the frame, bottom repeats middle
        logic top_mid;    // first real row, top repeats middle
        logic emit;       // this visit yields a result
        logic right_pre;  // right-edge pixel, taken before the shift
        logic left_new;   // left column is the newest window column
        logic last;       // result is the frame's final pixel
    } t_op_ctl;

endpackage

// File: rtl/sobel_gradient_clamped_unit.sv
`timescale 1ns / 1ps
// One word per cycle unless stalled; a flush at column zero of a one-row frame visits twice.
// Rate is set by the single read and write port of each line store, used once per visit.
// A result comes from the word one row and one pixel later and passes stages b, c and output.
// Reset (synchronous, active low): positions, queue and pipeline cleared, registers to defaults.
// Line stores are not cleared; no clearing pass, an item may follow reset at once.

module sobel_gradient_clamped_unit import sgc_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_COLS);

    logic [COL_CNT_W-1:0] r_col_count;
    logic [ROW_CNT_W-1:0] r_row_count;
    logic [SCALE_W-1:0]   r_grad_scale;
    logic                 cfg_wr, restart;

    logic                          push, q_full, q_valid, q_pop;
    t_op_ctl                       f_ctl, q_ctl;
    logic [COL_W-1:0]              f_col, q_col;
    logic signed [SAMPLE_BITS-1:0] f_sample, q_sample;

    // configuration registers; a size write restarts the frame
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_comb begin
        case (i_cfg_index)
            CFG_COL_COUNT:  restart = cfg_wr;
            CFG_ROW_COUNT:  restart = cfg_wr;
            default:        restart = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count  <= COL_COUNT_RST;
            r_row_count  <= ROW_COUNT_RST;
            r_grad_scale <= GRAD_SCALE_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_COL_COUNT:  r_col_count  <= i_cfg_data[COL_CNT_W-1:0];
                CFG_ROW_COUNT:  r_row_count  <= i_cfg_data[ROW_CNT_W-1:0];
                CFG_GRAD_SCALE: r_grad_scale <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: positions and classification
    sgc_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_col_count (r_col_count),
        .i_row_count (r_row_count),
        .i_restart   (restart),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_ctl       (f_ctl),
        .o_col       (f_col),
        .o_sample    (f_sample)
    );

    // queue between front and back
    sgc_queue #(
        .COL_W (COL_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_ctl    (f_ctl),
        .i_col    (f_col),
        .i_sample (f_sample),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_ctl    (q_ctl),
        .o_col    (q_col),
        .o_sample (q_sample)
    );

    // back: line stores, window and scaling
    sgc_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_ctl      (q_ctl),
        .i_q_col      (q_col),
        .i_q_sample   (q_sample),
        .o_q_pop      (q_pop),
        .i_grad_scale (r_grad_scale),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word),
        .i_out_stall  (i_out_stall)
    );

endmodule

// File: rtl/sgc_front.sv
`timescale 1ns / 1ps

module sgc_front import sgc_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [COL_CNT_W-1:0]          i_col_count,
    input  logic [ROW_CNT_W-1:0]          i_row_count,
    input  logic                          i_restart,
    input  logic                          i_in_valid,
    input  t_in_word                      i_in_word,
    output logic                          o_in_stall,
    input  logic                          i_q_full,
    output logic                          o_push,
    output t_op_ctl                       o_ctl,
    output logic [$clog2(MAX_COLS)-1:0]   o_col,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS + 2);

    logic [COL_W-1:0] r_col, n_col, v_col;
    logic [ROW_W-1:0] r_row, n_row, v_row;
    logic             r_pend, n_pend;

    logic [31:0]      col_req, row_req;
    logic [COL_W-1:0] cols_m1;
    logic [ROW_W-1:0] rows, rows_p1;

    logic             at_edge, at_norm, virt;
    t_op_ctl          ctl;
    logic             in_stall, accept, take_pix, take_flush, second, go;

    // frame size in use, clamped to the build limits, zero taken as one
    always_comb begin
        col_req = 32'(i_col_count);
        row_req = 32'(i_row_count);
        if (col_req == 32'd0) begin
            cols_m1 = '0;
        end else if (col_req > 32'(MAX_COLS)) begin
            cols_m1 = COL_W'(MAX_COLS - 1);
        end else begin
            cols_m1 = COL_W'(col_req - 32'd1);
        end
        if (row_req == 32'd0) begin
            rows = ROW_W'(1);
        end else if (row_req > 32'(MAX_ROWS)) begin
            rows = ROW_W'(MAX_ROWS);
        end else begin
            rows = ROW_W'(row_req);
        end
        rows_p1 = rows + ROW_W'(1);
    end

    // classify the visit at the current position
    always_comb begin
        at_edge       = (r_col == '0) && (r_row >= ROW_W'(2));
        at_norm       = (r_col != '0) && (r_row != '0);
        virt          = r_pend || (i_in_word.action == ACT_FLUSH);
        ctl.upd       = (r_row <= rows);
        ctl.virt      = virt;
        ctl.wr        = (r_row <= rows) && !virt;
        ctl.top_mid   = (r_row == ROW_W'(1));
        ctl.emit      = at_edge || at_norm;
        ctl.right_pre = at_edge;
        ctl.left_new  = at_edge ? (cols_m1 == '0) : (r_col == COL_W'(1));
        ctl.last      = at_edge && (r_row == rows_p1);
        if (r_row >= rows_p1) begin
            v_col = '0;
            v_row = '0;
        end else if (r_col != cols_m1) begin
            v_col = r_col + COL_W'(1);
            v_row = r_row;
        end else begin
            v_col = '0;
            v_row = r_row + ROW_W'(1);
        end
    end

    // input handshake; a flush that yields nothing is followed by a second visit
    always_comb begin
        in_stall   = r_pend || i_q_full;
        accept     = i_in_valid && !in_stall;
        take_pix   = accept && (i_in_word.action == ACT_PIXEL) && (r_row < rows);
        take_flush = accept && (i_in_word.action == ACT_FLUSH) && (r_row >= rows);
        second     = r_pend && !i_q_full;
        go         = take_pix || take_flush || second;
    end

    // next position and pending flag
    always_comb begin
        if (i_restart) begin
            n_col  = '0;
            n_row  = '0;
            n_pend = 1'b0;
        end else begin
            n_col  = go ? v_col : r_col;
            n_row  = go ? v_row : r_row;
            if (second) begin
                n_pend = 1'b0;
            end else if (take_flush && !ctl.emit) begin
                n_pend = 1'b1;
            end else begin
                n_pend = r_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
        end
    end

    assign o_in_stall = in_stall;
    assign o_push     = go;
    assign o_ctl      = ctl;
    assign o_col      = r_col;
    assign o_sample   = i_in_word.sample;

    // the second visit of a flush always gives a result
    a_second_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ctl.emit)
        else $error("second flush visit without a result");

    // a second visit always lies below the frame, never inside it
    a_pend_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_row >= rows))
        else $error("pending flush visit inside the frame");

endmodule

// File: rtl/sgc_queue.sv
`timescale 1ns / 1ps

module sgc_queue import sgc_pkg::*; #(
    parameter int COL_W = $clog2(MAX_COLS_DEF)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  t_op_ctl                       i_ctl,
    input  logic [COL_W-1:0]              i_col,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_full,
    input  logic                          i_pop,
    output logic                          o_valid,
    output t_op_ctl                       o_ctl,
    output logic [COL_W-1:0]              o_col,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op_ctl                       r_ctl    [QUEUE_DEPTH];
    logic [COL_W-1:0]              r_col    [QUEUE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_sample [QUEUE_DEPTH];
    logic [PTR_W-1:0]              r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]              r_count;
    logic                          do_pop;

    assign do_pop = i_pop && (r_count != '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wr_ptr]    <= i_ctl;
            r_col[r_wr_ptr]    <= i_col;
            r_sample[r_wr_ptr] <= i_sample;
        end
    end

    assign o_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_ctl    = r_ctl[r_rd_ptr];
    assign o_col    = r_col[r_rd_ptr];
    assign o_sample = r_sample[r_rd_ptr];

    // the front only pushes when there is room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    // fill count stays within the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: rtl/sgc_back.sv
`timescale 1ns / 1ps

module sgc_back import sgc_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  t_op_ctl                       i_q_ctl,
    input  logic [$clog2(MAX_COLS)-1:0]   i_q_col,
    input  logic signed [SAMPLE_BITS-1:0] i_q_sample,
    output logic                          o_q_pop,
    input  logic [SCALE_W-1:0]            i_grad_scale,
    output logic                          o_out_valid,
    output t_out_word                     o_out_word,
    input  logic                          i_out_stall
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int RAW_W  = SAMPLE_BITS + 3;
    localparam int PROD_W = RAW_W + SCALE_W + 1;
    localparam int Q_W    = PROD_W - SCALE_SHIFT;
    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(2 ** (GRAD_BITS - 1) - 1);
    localparam logic signed [Q_W-1:0] SAT_LO = ~SAT_HI;

    // weighted 1,2,1 sum of three samples
    function automatic logic signed [RAW_W-1:0] wsum(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input logic signed [SAMPLE_BITS-1:0] c
    );
        return RAW_W'(a) + (RAW_W'(b) <<< 1) + RAW_W'(c);
    endfunction

    // floor shift and saturate to the output width
    function automatic logic signed [GRAD_BITS-1:0] sat_grad(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [Q_W-1:0] q;
        q = p[PROD_W-1:SCALE_SHIFT];
        if (q > SAT_HI) begin
            return GRAD_BITS'(SAT_HI);
        end else if (q < SAT_LO) begin
            return GRAD_BITS'(SAT_LO);
        end
        return GRAD_BITS'(q);
    endfunction

    logic signed [SAMPLE_BITS-1:0] r_mem_up  [MAX_COLS];
    logic signed [SAMPLE_BITS-1:0] r_mem_mid [MAX_COLS];

    logic                          adv;
    logic                          r_a_v, r_b_v, r_c_v, r_out_v;
    t_op_ctl                       r_a_ctl;
    logic [COL_W-1:0]              r_a_col;
    logic signed [SAMPLE_BITS-1:0] r_a_sample;
    logic signed [SAMPLE_BITS-1:0] r_up_rd, r_mid_rd;

    logic                          r_fw_v;
    logic [COL_W-1:0]              r_fw_col;
    logic signed [SAMPLE_BITS-1:0] r_fw_up, r_fw_mid;

    t_win_col                      r_w [3];

    logic signed [SAMPLE_BITS-1:0] up_e, mid_e;
    logic                          fw_hit, a_wr;
    t_win_col                      new_col, col_l, col_m, col_r;
    logic signed [RAW_W-1:0]       gx, gy;

    logic signed [RAW_W-1:0]       r_b_gx, r_b_gy;
    logic                          r_b_last;
    logic signed [PROD_W-1:0]      r_c_px, r_c_py;
    logic                          r_c_last;
    t_out_word                     r_out_word;

    // whole back pipeline moves while the output register can take a word
    assign adv     = !r_out_v || !i_out_stall;
    assign o_q_pop = adv && i_q_valid;

    // stage a: line store data, with the write of the previous visit forwarded
    always_comb begin
        fw_hit  = r_fw_v && (r_fw_col == r_a_col);
        up_e    = fw_hit ? r_fw_up : r_up_rd;
        mid_e   = fw_hit ? r_fw_mid : r_mid_rd;
        a_wr    = r_a_v && r_a_ctl.wr;
        new_col.top = r_a_ctl.top_mid ? mid_e : up_e;
        new_col.mid = mid_e;
        new_col.bot = r_a_ctl.virt ? mid_e : r_a_sample;
    end

    // kernel columns: right-edge pixel uses the window before the shift
    always_comb begin
        col_l = r_a_ctl.left_new ? r_w[2] : r_w[1];
        col_m = r_w[2];
        col_r = r_a_ctl.right_pre ? r_w[2] : new_col;
        gx = wsum(col_l.top, col_l.mid, col_l.bot) - wsum(col_r.top, col_r.mid, col_r.bot);
        gy = wsum(col_l.top, col_m.top, col_r.top) - wsum(col_l.bot, col_m.bot, col_r.bot);
    end

    // line stores, read as a visit leaves the queue, written in stage a
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (a_wr) begin
                r_mem_up[r_a_col]  <= mid_e;
                r_mem_mid[r_a_col] <= r_a_sample;
            end
            r_up_rd  <= r_mem_up[i_q_col];
            r_mid_rd <= r_mem_mid[i_q_col];
        end
    end

    // stage valids and forward flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_out_v <= 1'b0;
            r_fw_v  <= 1'b0;
        end else if (adv) begin
            r_a_v   <= i_q_valid;
            r_b_v   <= r_a_v && r_a_ctl.emit;
            r_c_v   <= r_b_v;
            r_out_v <= r_c_v;
            r_fw_v  <= a_wr;
        end
    end

    // window shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w[0] <= '0;
            r_w[1] <= '0;
            r_w[2] <= '0;
        end else if (adv && r_a_v && r_a_ctl.upd) begin
            r_w[0] <= r_w[1];
            r_w[1] <= r_w[2];
            r_w[2] <= new_col;
        end
    end

    // payload of stages a, b, c, the forward registers and the output register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_ctl    <= i_q_ctl;
            r_a_col    <= i_q_col;
            r_a_sample <= i_q_sample;
            r_fw_col   <= r_a_col;
            r_fw_up    <= mid_e;
            r_fw_mid   <= r_a_sample;
            r_b_gx     <= gx;
            r_b_gy     <= gy;
            r_b_last   <= r_a_ctl.last;
            r_c_px     <= r_b_gx * $signed({1'b0, i_grad_scale});
            r_c_py     <= r_b_gy * $signed({1'b0, i_grad_scale});
            r_c_last   <= r_b_last;
            r_out_word.grad_x        <= sat_grad(r_c_px);
            r_out_word.grad_y        <= sat_grad(r_c_py);
            r_out_word.last_of_frame <= r_c_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out_word;

    // a held visit in stage a keeps its column
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v && !adv) |=> (r_a_v && $stable(r_a_col) && $stable(r_a_ctl)))
        else $error("stage a lost its visit during a stall");

endmodule

// File: bench/tb_sobel_gradient_clamped_unit.sv
`timescale 1ns / 1ps

module tb_sobel_gradient_clamped_unit;
    import sgc_pkg::*;

    localparam int    CYCLE_LIMIT = 500000;
    localparam int    RAND_ITEMS  = 560;
    localparam int    DRAIN_WAIT  = 8;
    localparam longint GRAD_HI    = (longint'(1) << (GRAD_BITS - 1)) - 1;
    localparam longint GRAD_LO    = -GRAD_HI - 1;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // clock, reset and block inputs
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_word              i_in_word   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_word             o_out_word;
    logic                  o_cfg_ready;

    int n_err     = 0;
    int n_cycles  = 0;
    int gap_pct   = 36;
    int n_taken   = 0;

    t_out_word pending_grads [$];

    always #5 i_clk = ~i_clk;

    sobel_gradient_clamped_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // gradient predictor: line stores, window and raster positions
    // ------------------------------------------------------------------
    logic [COL_CNT_W-1:0]          cols_reg;
    logic [ROW_CNT_W-1:0]          rows_reg;
    logic [SCALE_W-1:0]            scale_reg;
    logic signed [SAMPLE_BITS-1:0] row_up  [MAX_COLS_DEF];
    logic signed [SAMPLE_BITS-1:0] row_mid [MAX_COLS_DEF];
    t_win_col                      win [3];
    int unsigned                   at_col, at_row, res_col, res_row;

    function automatic int unsigned act_cols();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
        return cols_reg;
    endfunction

    function automatic int unsigned act_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
        return rows_reg;
    endfunction

    function automatic void frame_restart();
        at_col  = 0;
        at_row  = 0;
        res_col = 0;
        res_row = 0;
    endfunction

    // multiply by the q4.12 factor, floor, then clip to the output range
    function automatic logic signed [GRAD_BITS-1:0] scale_clip(input longint raw);
        longint q;
        q = (raw * longint'(scale_reg)) >>> SCALE_SHIFT;
        if (q > GRAD_HI) q = GRAD_HI;
        if (q < GRAD_LO) q = GRAD_LO;
        return q[GRAD_BITS-1:0];
    endfunction

    // gradients from left, middle and right window columns
    function automatic t_out_word sobel_result(input t_win_col l, input t_win_col m,
                                               input t_win_col r);
        longint    gx, gy;
        t_out_word res;
        gx = (longint'(l.top) + 2 * longint'(l.mid) + longint'(l.bot))
           - (longint'(r.top) + 2 * longint'(r.mid) + longint'(r.bot));
        gy = (longint'(l.top) + 2 * longint'(m.top) + longint'(r.top))
           - (longint'(l.bot) + 2 * longint'(m.bot) + longint'(r.bot));
        res.grad_x        = scale_clip(gx);
        res.grad_y        = scale_clip(gy);
        res.last_of_frame = (res_row == act_rows() - 1) && (res_col == act_cols() - 1);
        if (res_col + 1 < act_cols()) begin
            res_col++;
        end else begin
            res_col = 0;
            res_row++;
        end
        return res;
    endfunction

    // one raster position; virt marks the row below the frame
    function automatic void sobel_visit(input logic signed [SAMPLE_BITS-1:0] s,
                                        input bit virt, output bit got,
                                        output t_out_word res);
        int unsigned cols, rows, i, c;
        t_win_col    fresh;
        cols = act_cols();
        rows = act_rows();
        i    = at_row;
        c    = at_col;
        got  = 1'b0;
        res  = '0;
        // right-edge pixel of the row two above
        if (c == 0 && i >= 2) begin
            res = sobel_result((cols >= 2) ? win[1] : win[2], win[2], win[2]);
            got = 1'b1;
        end
        // shift a new column into the window, top and bottom clamped at the edges
        if (i <= rows) begin
            fresh.mid = row_mid[c];
            fresh.top = (i == 1) ? row_mid[c] : row_up[c];
            fresh.bot = virt ? row_mid[c] : s;
            win[0]    = win[1];
            win[1]    = win[2];
            win[2]    = fresh;
            if (!virt) begin
                row_up[c]  = row_mid[c];
                row_mid[c] = s;
            end
        end
        // interior pixel, left column clamped at column zero
        if (c >= 1 && i >= 1) begin
            res = sobel_result((c == 1) ? win[1] : win[0], win[1], win[2]);
            got = 1'b1;
        end
        if (i >= rows + 1) begin
            frame_restart();
        end else if (c + 1 < cols) begin
            at_col = c + 1;
        end else begin
            at_col = 0;
            at_row = i + 1;
        end
    endfunction

    // one input word; took is low when the block ignores it
    function automatic void sobel_step(input t_in_word w, output bit took, output bit got,
                                       output t_out_word res);
        took = 1'b0;
        got  = 1'b0;
        res  = '0;
        if (w.action == ACT_PIXEL) begin
            if (at_row < act_rows()) begin
                took = 1'b1;
                sobel_visit(w.sample, 1'b0, got, res);
            end
        end else if (at_row >= act_rows()) begin
            took = 1'b1;
            sobel_visit('0, 1'b1, got, res);
            if (!got) sobel_visit('0, 1'b1, got, res);
        end
    endfunction

    function automatic void sobel_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_COL_COUNT: begin
                cols_reg = data[COL_CNT_W-1:0];
                frame_restart();
            end
            CFG_ROW_COUNT: begin
                rows_reg = data[ROW_CNT_W-1:0];
                frame_restart();
            end
            CFG_GRAD_SCALE: scale_reg = data[SCALE_W-1:0];
            default: ;
        endcase
    endfunction

    // append one expected result word
    function automatic void note_result(input t_out_word w);
        pending_grads = {pending_grads, w};
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // send one word with random gaps; typed rows carry their own expected result
    task automatic push_word(input t_in_word w, input bit typed, input t_out_word typed_res);
        bit        took, got;
        t_out_word res;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sobel_step(w, took, got, res);
        if (took) n_taken++;
        if (typed && !got) begin
            $error("directed word gave no result, expected one");
            n_err++;
        end
        if (got) note_result(typed ? typed_res : res);
    endtask

    // register write once the block has gone quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (pending_grads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sobel_config(idx, data);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return SAMPLE_BITS'($signed($urandom_range(128)) - 64);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_scale();
        case ($urandom_range(5))
            0: return 16'd4096;
            1: return GRAD_SCALE_RST;
            2: return 16'hFFFF;
            3: return 16'd0;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking and output stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word want;
        i_out_stall <= ($urandom_range(99) < gap_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_grads.size() == 0) begin
                $error("result word with nothing expected");
                n_err++;
            end else begin
                want = pending_grads.pop_front();
                if (o_out_word.grad_x !== want.grad_x) begin
                    $error("grad_x expected %0d got %0d", want.grad_x, o_out_word.grad_x);
                    n_err++;
                end
                if (o_out_word.grad_y !== want.grad_y) begin
                    $error("grad_y expected %0d got %0d", want.grad_y, o_out_word.grad_y);
                    n_err++;
                end
                if (o_out_word.last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame expected %0d got %0d",
                           want.last_of_frame, o_out_word.last_of_frame);
                    n_err++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_sobel_gradient_clamped_unit: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    typedef enum logic {ROW_CFG, ROW_WORD} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_in_word              word;
        bit                    typed;
        t_out_word             res;
    } t_dir_row;

    localparam t_out_word NO_RES = '0;

    // two-column one-row frames at full scale saturate; a one-pixel frame gives zero
    t_dir_row dir_tab [25] = '{
        '{ROW_CFG,  CFG_GRAD_SCALE, 16'hFFFF, {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_COL_COUNT,  16'd2,    {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_ROW_COUNT,  16'd1,    {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_UNUSED,     16'h5A5A, {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_PIXEL, 16'h7FFF}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_PIXEL, 16'h8000}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_PIXEL, 16'h0005}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_FLUSH, 16'h0000}, 1'b1,
          {20'sh7FFFF, 20'sh00000, 1'b0}},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_FLUSH, 16'h0000}, 1'b1,
          {20'sh7FFFF, 20'sh00000, 1'b1}},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_PIXEL, 16'h8000}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_PIXEL, 16'h7FFF}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_FLUSH, 16'h0000}, 1'b1,
          {20'sh80000, 20'sh00000, 1'b0}},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_FLUSH, 16'h0000}, 1'b1,
          {20'sh80000, 20'sh00000, 1'b1}},
        '{ROW_CFG,  CFG_COL_COUNT,  16'h0000, {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_ROW_COUNT,  16'hE000, {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_PIXEL, 16'h8000}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_FLUSH, 16'h0000}, 1'b1,
          {20'sh00000, 20'sh00000, 1'b1}},
        '{ROW_CFG,  CFG_COL_COUNT,  16'hFFFF, {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_ROW_COUNT,  16'hFFFF, {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_PIXEL, 16'h0001}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_PIXEL, 16'hFFFF}, 1'b0, NO_RES},
        '{ROW_WORD, CFG_UNUSED,     16'h0000, {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_GRAD_SCALE, 16'h0000, {ACT_FLUSH, 16'h0000}, 1'b0, NO_RES}
    };

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int          frame_no, n_pix, stop_at, n_flush, pick;
        bit          abandon;
        int unsigned cw, rw;

        // predictor to its reset state
        foreach (row_up[k]) begin
            row_up[k]  = '0;
            row_mid[k] = '0;
        end
        foreach (win[k]) win[k] = '0;
        cols_reg  = COL_COUNT_RST;
        rows_reg  = ROW_COUNT_RST;
        scale_reg = GRAD_SCALE_RST;
        frame_restart();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (dir_tab[n]) begin
            if (dir_tab[n].kind == ROW_CFG) begin
                write_reg(dir_tab[n].idx, dir_tab[n].data);
            end else begin
                push_word(dir_tab[n].word, dir_tab[n].typed, dir_tab[n].res);
            end
        end

        // random frames, mostly well formed with some noise and abandoned frames
        n_taken  = 0;
        frame_no = 0;
        while (n_taken < RAND_ITEMS) begin
            frame_no++;
            gap_pct = (frame_no >= 6 && frame_no <= 12) ? 0 : 36;
            if (frame_no == 1 || $urandom_range(99) < 45) begin
                pick = $urandom_range(99);
                cw   = (pick < 8) ? 0 : (pick < 70) ? $urandom_range(1, 6)
                                                    : $urandom_range(7, 24);
                pick = $urandom_range(99);
                rw   = (pick < 8) ? 0 : (pick < 60) ? $urandom_range(1, 4)
                                                    : $urandom_range(5, 10);
                write_reg(CFG_COL_COUNT, {5'($urandom), 11'(cw)});
                write_reg(CFG_ROW_COUNT, {3'($urandom), 13'(rw)});
            end
            if (frame_no == 1 || $urandom_range(99) < 40) write_reg(CFG_GRAD_SCALE, rand_scale());

            n_pix   = act_cols() * act_rows();
            abandon = (n_pix > 1) && ($urandom_range(99) < 8);
            stop_at = abandon ? $urandom_range(1, n_pix - 1) : n_pix;
            for (int p = 0; p < stop_at; p++) begin
                if ($urandom_range(99) < 4) push_word({ACT_FLUSH, rand_sample()}, 1'b0, NO_RES);
                push_word({ACT_PIXEL, rand_sample()}, 1'b0, NO_RES);
            end
            if (abandon) begin
                // rewriting the row count drops the half-done frame
                write_reg(CFG_ROW_COUNT, {3'b000, rows_reg});
            end else begin
                if ($urandom_range(99) < 20) push_word({ACT_PIXEL, rand_sample()}, 1'b0, NO_RES);
                n_flush = act_cols() + ((act_rows() > 1) ? 1 : 0);
                for (int f = 0; f < n_flush; f++) begin
                    push_word({ACT_FLUSH, SAMPLE_BITS'($urandom)}, 1'b0, NO_RES);
                end
                if ($urandom_range(99) < 15) push_word({ACT_FLUSH, rand_sample()}, 1'b0, NO_RES);
            end
        end

        // drain and finish
        i_in_valid <= 1'b0;
        while (pending_grads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT + 4) @(posedge i_clk);
        if (n_err == 0) begin
            $display("tb_sobel_gradient_clamped_unit: done, clean");
        end else begin
            $display("tb_sobel_gradient_clamped_unit: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/sgc_pkg.sv
rtl/sgc_front.sv
rtl/sgc_queue.sv
rtl/sgc_back.sv
rtl/sobel_gradient_clamped_unit.sv
bench/tb_sobel_gradient_clamped_unit.sv
